@@ hdl/giq_pkg.sv @@
package giq_pkg;

	// Fixed field widths
	localparam int HANDLE_W  = 16;
	localparam int LEN_W     = 3;
	localparam int PAYLOAD_W = 40;
	localparam int PAYLOAD_BYTES = PAYLOAD_W / 8;
	localparam int KIND_W    = 3;
	localparam int LEVEL_W   = 3;
	localparam int FLAGS_W   = 2;
	localparam int COUNT_W   = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Event codes
	localparam logic [KIND_W-1:0] KIND_ENQUEUE    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CONFIRM    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_OPEN       = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLOSE      = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SECURITY   = 3'd5;
	localparam logic [KIND_W-1:0] KIND_CLIENT_CFG = 3'd6;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_HANDLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROX_HANDLE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH   = 2'd2;

	// Register reset values
	localparam logic [HANDLE_W-1:0] TOUCH_HANDLE_RST = 16'd1;
	localparam logic [HANDLE_W-1:0] PROX_HANDLE_RST  = 16'd2;
	localparam logic [LEN_W-1:0]    MIN_LENGTH_RST   = 3'd1;

	// Security level above this marks the link bonded
	localparam logic [LEVEL_W-1:0] BOND_LEVEL_MIN = 3'd1;
	// Client config bit that enables indications
	localparam int FLAG_INDICATE = 1;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [HANDLE_W-1:0]  char_handle;
		logic [LEN_W-1:0]     payload_length;
		logic [PAYLOAD_W-1:0] payload;
		logic [LEVEL_W-1:0]   security_level;
		logic [FLAGS_W-1:0]   config_flags;
	} item_t;

	typedef struct packed {
		logic                 sent;
		logic [HANDLE_W-1:0]  sent_handle;
		logic [LEN_W-1:0]     sent_length;
		logic [PAYLOAD_W-1:0] sent_payload;
		logic                 write_rejected;
		logic                 entry_dropped;
		logic [COUNT_W-1:0]   queue_count;
		logic                 in_flight;
	} result_t;

	typedef struct packed {
		logic [HANDLE_W-1:0]  handle;
		logic [LEN_W-1:0]     length;
		logic [PAYLOAD_W-1:0] payload;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FLUSH,
		ST_READ,
		ST_RESULT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic take_item;
		logic exec;
		logic clear_ptrs;
		logic read_head;
		logic pop;
		logic load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic flush_kind;
		logic link_up;
		logic can_pop;
	} status_t;

endpackage

@@ hdl/gated_indication_queue.sv @@
// Channel   Direction  Handshake                    Word
// item      in         item_valid / item_ready      item   (item_t)
// result    out        result_valid / result_ready  result (result_t)
// cfg       in         cfg_valid / cfg_ready        cfg_index, cfg_data
//
// An item holds the block from accept through the load of its result. It steps
// through accept, execute and load when it does not flush; a flush adds the flush
// step, which clears or finds nothing to pop, or pops the head through the
// registered RAM read step before the load. A stalled result holds the load step,
// and with it the next item. Reset (arst_n low) empties the queue and clears all link
// flags; the RAM holds no valid bits, since only written slots are ever read.
module gated_indication_queue
	import giq_pkg::*;
#(
	parameter int QUEUE_SLOTS = 16,
	parameter int MAX_LEN     = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	// Registers must be written only while the block is idle; the block does not enforce this, so take every word.
	assign cfg_ready = 1'b1;

	// Sequence each item: accept, apply the event, flush for an enqueue or confirm, load the result.
	giq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// Hold the queue RAM, pointers, link flags, registers and result word.
	giq_dp #(
		.QUEUE_SLOTS (QUEUE_SLOTS),
		.MAX_LEN     (MAX_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule

@@ hdl/giq_ram.sv @@
module giq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/giq_ctrl.sv @@
module giq_ctrl
	import giq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	output logic    result_valid,
	input  logic    result_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.take_item = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = status.flush_kind ? ST_FLUSH : ST_RESULT;
			end
			ST_FLUSH: begin
				if (!status.link_up) begin
					cmd.clear_ptrs = 1'b1;
					state_d        = ST_RESULT;
				end else if (status.can_pop) begin
					cmd.read_head = 1'b1;
					state_d       = ST_READ;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_READ: begin
				cmd.pop = 1'b1;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || result_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign result_valid = out_valid_q;

endmodule

@@ hdl/giq_dp.sv @@
module giq_dp
	import giq_pkg::*;
#(
	parameter int QUEUE_SLOTS = 16,
	parameter int MAX_LEN     = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  item_t                 item,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  cmd,
	output status_t               status,
	output result_t               result
);

	localparam int PW = $clog2(QUEUE_SLOTS);
	localparam int CW = $clog2(QUEUE_SLOTS + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_SLOTS - 1);
	localparam logic [LEN_W:0] MAX_LEN_X = (LEN_W + 1)'(MAX_LEN);

	item_t                 item_q;
	logic [PW-1:0]         wp_q, rp_q, wp_next, rp_next;
	logic                  link_up_q, bonded_q, await_q, touch_en_q, prox_en_q;
	logic [HANDLE_W-1:0]   touch_handle_q, prox_handle_q;
	logic [LEN_W-1:0]      min_len_q;
	logic                  res_sent_q, res_rej_q, res_drop_q;
	logic [HANDLE_W-1:0]   res_handle_q;
	logic [LEN_W-1:0]      res_len_q;
	logic [PAYLOAD_W-1:0]  res_payload_q;
	result_t               result_q;

	logic                  enq_reject, ram_we, head_ok;
	logic [PAYLOAD_W-1:0]  masked_payload;
	entry_t                wr_entry, head;
	logic [ENTRY_W-1:0]    rd_bits;
	logic [CW-1:0]         held;

	assign wp_next = (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
	assign rp_next = (rp_q == LAST_SLOT) ? '0 : rp_q + 1'b1;

	assign held = (wp_q >= rp_q) ? CW'(wp_q) - CW'(rp_q)
	                             : CW'(wp_q) + CW'(QUEUE_SLOTS) - CW'(rp_q);

	assign enq_reject = ({1'b0, item_q.payload_length} > MAX_LEN_X)
	                 || (item_q.payload_length < min_len_q)
	                 || (wp_next == rp_q);

	// Keep only the bytes below the length
	always_comb begin
		for (int b = 0; b < PAYLOAD_BYTES; b++) begin
			masked_payload[b*8 +: 8] = (LEN_W'(b) < item_q.payload_length)
			                         ? item_q.payload[b*8 +: 8] : 8'h00;
		end
	end

	assign wr_entry = '{handle: item_q.char_handle, length: item_q.payload_length,
	                    payload: masked_payload};
	assign ram_we   = cmd.exec && (item_q.kind == KIND_ENQUEUE) && !enq_reject;

	giq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (wr_entry),
		.re    (cmd.read_head),
		.raddr (rp_q),
		.rdata (rd_bits)
	);

	assign head    = entry_t'(rd_bits);
	assign head_ok = bonded_q && (((head.handle == touch_handle_q) && touch_en_q)
	                           || ((head.handle == prox_handle_q) && prox_en_q));

	assign status.flush_kind = (item_q.kind == KIND_ENQUEUE) || (item_q.kind == KIND_CONFIRM);
	assign status.link_up    = link_up_q;
	assign status.can_pop    = !await_q && (wp_q != rp_q);

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			item_q <= item;
		end
		if (cmd.exec) begin
			res_sent_q    <= 1'b0;
			res_handle_q  <= '0;
			res_len_q     <= '0;
			res_payload_q <= '0;
			res_drop_q    <= 1'b0;
			res_rej_q     <= (item_q.kind == KIND_ENQUEUE) && enq_reject;
		end
		if (cmd.pop) begin
			if (head_ok) begin
				res_sent_q    <= 1'b1;
				res_handle_q  <= head.handle;
				res_len_q     <= head.length;
				res_payload_q <= head.payload;
			end else begin
				res_drop_q <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			result_q <= '{sent: res_sent_q, sent_handle: res_handle_q,
			              sent_length: res_len_q, sent_payload: res_payload_q,
			              write_rejected: res_rej_q, entry_dropped: res_drop_q,
			              queue_count: COUNT_W'(held), in_flight: await_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q           <= '0;
			rp_q           <= '0;
			link_up_q      <= 1'b0;
			bonded_q       <= 1'b0;
			await_q        <= 1'b0;
			touch_en_q     <= 1'b0;
			prox_en_q      <= 1'b0;
			touch_handle_q <= TOUCH_HANDLE_RST;
			prox_handle_q  <= PROX_HANDLE_RST;
			min_len_q      <= MIN_LENGTH_RST;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					CFG_TOUCH_HANDLE: touch_handle_q <= cfg_data;
					CFG_PROX_HANDLE:  prox_handle_q  <= cfg_data;
					CFG_MIN_LENGTH:   min_len_q      <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.exec) begin
				case (item_q.kind) inside
					KIND_ENQUEUE: begin
						if (!enq_reject) begin
							wp_q <= wp_next;
						end
					end
					KIND_CONFIRM, KIND_TIMEOUT: begin
						await_q <= 1'b0;
					end
					KIND_OPEN: begin
						link_up_q <= 1'b1;
					end
					KIND_CLOSE: begin
						link_up_q  <= 1'b0;
						touch_en_q <= 1'b0;
						prox_en_q  <= 1'b0;
					end
					KIND_SECURITY: begin
						if (item_q.security_level > BOND_LEVEL_MIN) begin
							bonded_q <= 1'b1;
						end
					end
					KIND_CLIENT_CFG: begin
						if (item_q.char_handle == touch_handle_q) begin
							touch_en_q <= item_q.config_flags[FLAG_INDICATE];
						end else if (item_q.char_handle == prox_handle_q) begin
							prox_en_q <= item_q.config_flags[FLAG_INDICATE];
						end
					end
					default: ;
				endcase
			end
			if (cmd.clear_ptrs) begin
				wp_q <= '0;
				rp_q <= '0;
			end
			if (cmd.pop) begin
				rp_q <= rp_next;
				if (head_ok) begin
					await_q <= 1'b1;
				end
			end
		end
	end

	assign result = result_q;

endmodule

@@ hdl/giq_checker.sv @@
module giq_checker
	import giq_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	// A stalled result word holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// A sent indication is in flight and was not dropped.
	a_sent_flight: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.sent |-> result.in_flight && !result.entry_dropped)
		else $error("sent indication not marked in flight or also dropped");

	// With nothing sent, the indication fields read as zero.
	a_unsent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.sent |-> result.sent_handle == '0
			&& result.sent_length == '0 && result.sent_payload == '0)
		else $error("indication fields set without a send");

endmodule

bind gated_indication_queue giq_checker u_giq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
